### design/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DATA_W = 32;

    // operation codes carried on s_axis tuser
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result status codes carried on m_axis tuser
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam int COUNT_OUT_W = 7;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } ctrl_t;

endpackage

### design/sorted_priority_queue.sv
`timescale 1ns / 1ps
// sorted priority queue built as a chain of compare-and-shift cells
// input stream: s_axis_tuser selects the operation (0 enqueue, 1 dequeue),
//   s_axis_tdata carries the value and its priority (lower number served first)
// output stream: one word per accepted input word, m_axis_tuser is the status
//   (ok, overflow on a full enqueue, underflow on an empty dequeue) and
//   m_axis_tdata reports the removed value and the queue view after the step
// equal priorities leave in arrival order
// every cell compares the new priority against its own entry in the same
//   cycle and either holds, takes the new word or takes its neighbor's entry,
//   so one operation completes per clock while the result stream is not
//   stalled: the result word is registered, throughput is 1 word per cycle
// a single output register holds the result; when the receiver stalls the
//   input is held off until that word is taken
// reset empties the queue at once (count to zero, output invalid); the cell
//   contents are left as they are and are never read before being written
// CAPACITY sets the number of cells; entry_count reports the low 7 bits

module sorted_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // [31:0] value, [63:32] priority_req
    input  logic         s_axis_tuser,  // [0] kind
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] removed_value, [32] head_valid, [64:33] head_value,
    // [96:65] head_priority, [103:97] entry_count, [104] queue_full, rest zero
    output logic [111:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser   // [1:0] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    logic [1:0]       status_reg, status_next;
    logic signed [31:0] removed_reg, removed_next;
    logic signed [31:0] head_value_reg, head_value_next;
    logic signed [31:0] head_prio_reg, head_prio_next;
    logic             head_valid_reg, head_valid_next;
    logic             full_reg, full_next;
    logic [CNT_W-1:0] count_out_reg;

    logic accept, is_enq, q_full, q_empty;
    spq_pkg::ctrl_t ctrl;

    spq_pkg::entry_t cell_ent      [CAPACITY];
    spq_pkg::entry_t cell_ent_next [CAPACITY];
    logic            cell_keep     [CAPACITY];
    spq_pkg::entry_t prev_ent_w    [CAPACITY];
    spq_pkg::entry_t succ_ent_w    [CAPACITY];
    logic            prev_keep_w   [CAPACITY];

    // a stalled result word blocks new input
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_enq        = (s_axis_tuser == spq_pkg::KIND_ENQ);
    assign q_full        = (count_reg == CNT_W'(CAPACITY));
    assign q_empty       = (count_reg == '0);

    assign ctrl.enq   = accept && is_enq && !q_full;
    assign ctrl.deq   = accept && !is_enq && !q_empty;
    assign ctrl.value = s_axis_tdata[31:0];
    assign ctrl.prio  = s_axis_tdata[63:32];

    // the cell chain: neighbor links, head cell sees a virtual keeper ahead
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign prev_keep_w[gi] = 1'b1;
                assign prev_ent_w[gi]  = cell_ent[gi];
            end else begin : g_rest
                assign prev_keep_w[gi] = cell_keep[gi-1];
                assign prev_ent_w[gi]  = cell_ent[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign succ_ent_w[gi] = cell_ent[gi];
            end else begin : g_mid
                assign succ_ent_w[gi] = cell_ent[gi+1];
            end

            spq_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .occupied  (CNT_W'(gi) < count_reg),
                .prev_keep (prev_keep_w[gi]),
                .prev_ent  (prev_ent_w[gi]),
                .succ_ent  (succ_ent_w[gi]),
                .ent       (cell_ent[gi]),
                .keep      (cell_keep[gi]),
                .ent_next  (cell_ent_next[gi])
            );
        end
    endgenerate

    // result of the step; the head view is taken from the head cell's next contents
    always_comb begin
        count_next   = count_reg;
        status_next  = spq_pkg::ST_OK;
        removed_next = '0;
        if (ctrl.enq) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.deq) begin
            count_next   = count_reg - CNT_W'(1);
            removed_next = cell_ent[0].value;
        end else if (is_enq) begin
            status_next = spq_pkg::ST_OVERFLOW;
        end else begin
            status_next = spq_pkg::ST_UNDERFLOW;
        end
        head_valid_next = (count_next != '0);
        head_value_next = head_valid_next ? cell_ent_next[0].value : '0;
        head_prio_next  = head_valid_next ? cell_ent_next[0].prio  : '0;
        full_next       = (count_next == CNT_W'(CAPACITY));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg     <= status_next;
            removed_reg    <= removed_next;
            head_valid_reg <= head_valid_next;
            head_value_reg <= head_value_next;
            head_prio_reg  <= head_prio_next;
            full_reg       <= full_next;
            count_out_reg  <= count_next;
        end
    end

    // low bits of the count, zero extended when the counter is narrower
    logic [CNT_W+spq_pkg::COUNT_OUT_W-1:0] count_wide;
    assign count_wide = {{spq_pkg::COUNT_OUT_W{1'b0}}, count_out_reg};

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {7'b0, full_reg, count_wide[spq_pkg::COUNT_OUT_W-1:0],
                            head_prio_reg, head_value_reg, head_valid_reg, removed_reg};

endmodule

### design/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
    input  logic            aclk,
    input  spq_pkg::ctrl_t  ctrl,
    input  logic            occupied,
    input  logic            prev_keep,
    input  spq_pkg::entry_t prev_ent,
    input  spq_pkg::entry_t succ_ent,
    output spq_pkg::entry_t ent,
    output logic            keep,
    output spq_pkg::entry_t ent_next
);

    spq_pkg::entry_t ent_reg;

    // entry stays put when it is stored and ranks at or ahead of the new word
    assign keep = occupied && ($signed(ent_reg.prio) <= $signed(ctrl.prio));
    assign ent  = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        if (ctrl.enq) begin
            if (!keep) begin
                if (prev_keep) begin
                    ent_next.value = ctrl.value;
                    ent_next.prio  = ctrl.prio;
                end else begin
                    ent_next = prev_ent;
                end
            end
        end else if (ctrl.deq) begin
            ent_next = succ_ent;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

### design/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker #(
    parameter int CAPACITY = 64
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [63:0]  s_axis_tdata,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a stalled result word stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // every accepted input word gives a result word in the next cycle
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result word after accepted input");

    // empty view reads as zero
    a_empty_view: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[32] |->
            m_axis_tdata[64:33] == 32'd0 && m_axis_tdata[96:65] == 32'd0)
        else $error("empty queue shows a head");

    // underflow removes nothing and leaves the queue empty
    a_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == spq_pkg::ST_UNDERFLOW |->
            m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[32])
        else $error("underflow with queue contents");

    // overflow only happens on a full queue
    a_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == spq_pkg::ST_OVERFLOW |->
            m_axis_tdata[104] && m_axis_tdata[32])
        else $error("overflow reported on a queue that is not full");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
